// ===== rtl/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg
// Types and constants shared by the indexed shift list and its cells.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // wide enough for any position or count up to the largest capacity (64)
    localparam int POS_W = 7;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_DUMP   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } isl_state_t;

    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic [4:0]  index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  count_after;
        logic        has_entry;
        logic [3:0]  entry_position;
        logic [31:0] entry_value;
        logic        last;
    } result_t;

endpackage

// ===== rtl/isl_cell.sv =====
// ----------------------------------------------------------------------------
// isl_cell
// One list slot: takes its left or right neighbor, the head, or a new word.
// ----------------------------------------------------------------------------
module isl_cell #(
    parameter int DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF,
    parameter int POS        = 0
) (
    input  logic                   clk,
    input  isl_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]  wr_data,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    input  logic [DATA_WIDTH-1:0]  head_data,
    output logic [DATA_WIDTH-1:0]  data
);
    import isl_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_POS > ctrl.pos)
                    data_next = left_data;
                else if (MY_POS == ctrl.pos)
                    data_next = wr_data;
            end
            CELL_REMOVE:
            begin
                if (MY_POS >= ctrl.pos)
                    data_next = right_data;
            end
            CELL_ROTATE:
            begin
                if (MY_POS == ctrl.pos)
                    data_next = head_data;
                else
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/indexed_shift_list.sv =====
// ----------------------------------------------------------------------------
// indexed_shift_list
// Ordered list of fixed capacity held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Each result is registered and appears in the cycle after its item is accepted.
// Append, insert, remove, clear: one item per cycle, one result each.
// Dump of n entries: n results on consecutive cycles, busy while the rest are read out,
// as the cell row rotates one place per cycle past the head cell.
// Reset clears the count, the state and the strobe; entry cells are not reset.
// The receiver cannot stall results.
module indexed_shift_list #(
    parameter int CAPACITY   = isl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  isl_pkg::cmd_t    cmd,
    output logic             done,
    output isl_pkg::result_t result
);
    import isl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PTR_W = $clog2(CAPACITY);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    isl_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] wr_data;
    logic [63:0]           value_wide;
    logic [63:0]           head_wide;
    logic [POS_W-1:0]      count_pos;
    logic [POS_W-1:0]      index_pos;
    logic [CNT_W-1:0]      count_m1;
    logic                  accept;
    logic                  dump_end;

    assign accept     = start && (state_reg == S_IDLE);
    assign value_wide = 64'(cmd.value);
    assign wr_data    = value_wide[DATA_WIDTH-1:0];
    assign head_wide  = 64'(cell_data[0]);
    assign count_pos  = POS_W'(count_reg);
    assign index_pos  = POS_W'(cmd.index);
    assign count_m1   = count_reg - CNT_W'(1);
    assign dump_end   = (CNT_W'(ptr_reg) == count_m1);

    // cell row
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (gi == 0)
        begin : g_first
            assign left_d = wr_data;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[gi];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[gi+1];
        end

        isl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS        (gi)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .wr_data    (wr_data),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[gi])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && (cmd.mode == MODE_DUMP) && (count_reg > CNT_W'(1)))
                    state_next = S_DUMP;
            end
            S_DUMP:
            begin
                if (dump_end)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        done_next   = 1'b0;
        ctrl.op     = CELL_HOLD;
        ctrl.pos    = '0;
        result_next = '0;
        result_next.last = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    case (cmd.mode)
                        MODE_APPEND:
                        begin
                            if (count_pos >= CAP_POS)
                                result_next.status = ST_FULL;
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                ctrl.pos   = count_pos;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (index_pos > count_pos)
                                result_next.status = ST_RANGE;
                            else if (count_pos >= CAP_POS)
                                result_next.status = ST_FULL;
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                ctrl.pos   = index_pos;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (index_pos >= count_pos)
                                result_next.status = ST_RANGE;
                            else
                            begin
                                ctrl.op    = CELL_REMOVE;
                                ctrl.pos   = index_pos;
                                count_next = count_m1;
                            end
                        end
                        MODE_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                ctrl.op                    = CELL_ROTATE;
                                ctrl.pos                   = POS_W'(count_m1);
                                result_next.has_entry      = 1'b1;
                                result_next.entry_value    = head_wide[31:0];
                                result_next.last           = (count_reg == CNT_W'(1));
                                ptr_next                   = PTR_W'(1);
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                done_next                  = 1'b1;
                ctrl.op                    = CELL_ROTATE;
                ctrl.pos                   = POS_W'(count_m1);
                result_next.has_entry      = 1'b1;
                result_next.entry_position = 4'(ptr_reg);
                result_next.entry_value    = head_wide[31:0];
                result_next.last           = dump_end;
                ptr_next                   = ptr_reg + PTR_W'(1);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
        result_next.count_after = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg == S_DUMP);
    assign done   = done_reg;
    assign result = result_reg;

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg > CNT_W'(1)))
        else $error("dump running with fewer than two entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_pos <= CAP_POS)
        else $error("count above capacity");

    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !busy) |-> result_reg.last)
        else $error("final result of an item not marked last");

    a_dump_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.mode == MODE_DUMP) && (count_reg > CNT_W'(1))) |=> busy)
        else $error("multi-entry dump did not hold off new items");

    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(count_reg))
        else $error("count changed during dump");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed shift list: a queued command driver,
// a strobe monitor and a model of the list contents and count.
// ----------------------------------------------------------------------------
module tb;

    import isl_pkg::*;

    localparam int LIST_CAP    = 16;
    localparam int NUM_ITEMS   = 420;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;

    localparam logic [2:0] MODE_NOP_5 = 3'd5;
    localparam logic [2:0] MODE_NOP_6 = 3'd6;
    localparam logic [2:0] MODE_NOP_7 = 3'd7;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    cmd_t        pending_cmds[$];
    result_t     expected_results[$];
    logic [31:0] list_mem[LIST_CAP];
    int          list_count = 0;

    int gen_count = 0;
    int n_total   = 0;
    int n_acc     = 0;
    int n_errors  = 0;
    int stall_cnt = 0;
    int idle_pct;

    logic    drive_go;
    cmd_t    drive_cmd;
    result_t want;

    indexed_shift_list u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // list model, pushes the results one command produces
    task automatic predict_list_op(input cmd_t c);
        result_t r;
        status_t st;
        int      i;
        st = ST_OK;
        r  = '0;
        case (c.mode)
            MODE_APPEND:
                if (list_count >= LIST_CAP)
                    st = ST_FULL;
                else
                begin
                    list_mem[list_count] = c.value;
                    list_count++;
                end
            MODE_INSERT:
                if (c.index > list_count)
                    st = ST_RANGE;
                else if (list_count >= LIST_CAP)
                    st = ST_FULL;
                else
                begin
                    for (i = list_count; i > c.index; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[c.index] = c.value;
                    list_count++;
                end
            MODE_REMOVE:
                if (c.index >= list_count)
                    st = ST_RANGE;
                else
                begin
                    for (i = c.index; i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i+1];
                    list_count--;
                end
            MODE_DUMP:
                if (list_count != 0)
                begin
                    for (i = 0; i < list_count; i++)
                    begin
                        r.status         = ST_OK;
                        r.count_after    = list_count[4:0];
                        r.has_entry      = 1'b1;
                        r.entry_position = i[3:0];
                        r.entry_value    = list_mem[i];
                        r.last           = (i == list_count - 1);
                        expected_results.push_back(r);
                    end
                    return;
                end
            MODE_CLEAR:
                list_count = 0;
            default:
                ;
        endcase
        r.status      = st;
        r.count_after = list_count[4:0];
        r.last        = 1'b1;
        expected_results.push_back(r);
    endtask

    // stimulus queue with a shadow count to keep indexes mostly legal
    task automatic queue_cmd(input logic [2:0] mode, input logic [31:0] value,
                             input logic [4:0] index);
        cmd_t c;
        c.mode  = mode;
        c.value = value;
        c.index = index;
        pending_cmds.push_back(c);
        case (mode)
            MODE_APPEND:
                if (gen_count < LIST_CAP)
                    gen_count++;
            MODE_INSERT:
                if (index <= gen_count && gen_count < LIST_CAP)
                    gen_count++;
            MODE_REMOVE:
                if (index < gen_count)
                    gen_count--;
            MODE_CLEAR:
                gen_count = 0;
            default:
                ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, exp_val);
        n_errors++;
    endtask

    initial
    begin
        int sel;
        int k;
        // empty and short list corner cases
        queue_cmd(MODE_REMOVE, 32'h0, 5'd0);
        queue_cmd(MODE_DUMP, 32'h0, 5'd0);
        queue_cmd(MODE_INSERT, 32'h1234_5678, 5'd1);
        queue_cmd(MODE_INSERT, 32'hFFFF_FFFF, 5'd0);
        queue_cmd(MODE_APPEND, 32'h0, 5'd31);
        queue_cmd(MODE_INSERT, 32'hAAAA_AAAA, 5'd2);
        queue_cmd(MODE_INSERT, 32'h5555_5555, 5'd1);
        queue_cmd(MODE_REMOVE, 32'h0, 5'd4);
        queue_cmd(MODE_REMOVE, 32'hFFFF_FFFF, 5'd31);
        queue_cmd(MODE_DUMP, 32'h0, 5'd0);
        queue_cmd(MODE_REMOVE, 32'h0, 5'd0);
        queue_cmd(MODE_NOP_5, 32'hFFFF_FFFF, 5'd31);
        queue_cmd(MODE_NOP_7, 32'h0, 5'd0);
        queue_cmd(MODE_CLEAR, 32'h0, 5'd0);
        // fill to capacity, then the full and range cases, dumps and removes
        for (k = 0; k < LIST_CAP; k++)
            queue_cmd(MODE_APPEND, $urandom, 5'd0);
        queue_cmd(MODE_APPEND, 32'hDEAD_BEEF, 5'd0);
        queue_cmd(MODE_INSERT, 32'hDEAD_BEEF, 5'd16);
        queue_cmd(MODE_INSERT, 32'hDEAD_BEEF, 5'd17);
        queue_cmd(MODE_DUMP, 32'h0, 5'd0);
        queue_cmd(MODE_REMOVE, 32'h0, 5'd15);
        queue_cmd(MODE_REMOVE, 32'h0, 5'd0);
        queue_cmd(MODE_DUMP, 32'h0, 5'd0);
        queue_cmd(MODE_CLEAR, 32'h0, 5'd0);

        while (pending_cmds.size() < NUM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                queue_cmd(MODE_APPEND, pick_value(), 5'($urandom_range(0, 31)));
            else if (sel < 55)
            begin
                if ($urandom_range(0, 9) < 8)
                    queue_cmd(MODE_INSERT, pick_value(),
                              5'($urandom_range(0, gen_count)));
                else
                    queue_cmd(MODE_INSERT, pick_value(), 5'($urandom_range(0, 31)));
            end
            else if (sel < 77)
            begin
                if (gen_count > 0 && $urandom_range(0, 9) < 8)
                    queue_cmd(MODE_REMOVE, pick_value(),
                              5'($urandom_range(0, gen_count - 1)));
                else
                    queue_cmd(MODE_REMOVE, pick_value(), 5'($urandom_range(0, 31)));
            end
            else if (sel < 90)
                queue_cmd(MODE_DUMP, pick_value(), 5'($urandom_range(0, 31)));
            else if (sel < 95)
                queue_cmd(MODE_CLEAR, pick_value(), 5'($urandom_range(0, 31)));
            else
                queue_cmd(3'($urandom_range(MODE_NOP_5, MODE_NOP_7)), pick_value(),
                          5'($urandom_range(0, 31)));
        end
        n_total = pending_cmds.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_acc == n_total && expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0)
            $display("[indexed_shift_list] OK");
        else
            $display("[indexed_shift_list] ERROR");
        $finish;
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (n_acc < 150)
                idle_pct = 16;
            else if (n_acc < 300)
                idle_pct = 46;
            else
                idle_pct = 0;
            drive_go  = start;
            drive_cmd = cmd;
            if (start && !busy)
            begin
                predict_list_op(cmd);
                n_acc++;
                drive_go = 1'b0;
            end
            if (!drive_go && pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                drive_cmd = pending_cmds.pop_front();
                drive_go  = 1'b1;
            end
            start <= drive_go;
            cmd   <= drive_cmd;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result.entry_value, 32'h0);
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
                if (result.count_after !== want.count_after)
                    report_mismatch("count_after", 32'(result.count_after),
                                    32'(want.count_after));
                if (result.has_entry !== want.has_entry)
                    report_mismatch("has_entry", 32'(result.has_entry),
                                    32'(want.has_entry));
                if (result.entry_position !== want.entry_position)
                    report_mismatch("entry_position", 32'(result.entry_position),
                                    32'(want.entry_position));
                if (result.entry_value !== want.entry_value)
                    report_mismatch("entry_value", result.entry_value, want.entry_value);
                if (result.last !== want.last)
                    report_mismatch("last", 32'(result.last), 32'(want.last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("[indexed_shift_list] ERROR");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

endmodule
